### design/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Types and constants shared by the insertion sorter chain and its cells.
// ----------------------------------------------------------------------------
package isort_pkg;

   localparam int DATA_WIDTH = 32;

   // what one cell shows to its neighbors
   typedef struct packed {
      logic                  valid;
      logic                  gt;
      logic [DATA_WIDTH-1:0] value;
   } cell_link_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

### design/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// One stage of the sort chain: holds one element, compares it against the
// broadcast value and takes data from its lower or upper neighbor.
// ----------------------------------------------------------------------------
module isort_cell
   import isort_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] new_value,
   input  cell_link_type         prev_link,
   input  cell_link_type         next_link,
   output cell_link_type         link
);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic                  gt;

   // strict compare keeps equal values in arrival order
   assign gt = valid_ff && ($signed(value_ff) > $signed(new_value));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         // drain toward the head of the chain
         value_in = next_link.value;
         valid_in = next_link.valid;
      end else if (ctrl.insert) begin
         if (gt || (!valid_ff && prev_link.valid)) begin
            value_in = prev_link.gt ? prev_link.value : new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign link.valid = valid_ff;
   assign link.gt    = gt;
   assign link.value = value_ff;

endmodule

### design/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter
// Streaming sort of a run of signed 32-bit values in a chain of cells.
// ----------------------------------------------------------------------------
// Values of a run are accepted one per cycle and each is placed in order in a
// chain of MAX_ELEMENTS compare-and-shift cells in the cycle it arrives. The
// transaction with tlast set starts the drain: the chain shifts toward its
// head and the run leaves lowest first, one result per cycle while rsp_tready
// is high, the final result marked with rsp_tlast. The chain is both store and
// output shift line, so no input is taken while a run drains. Values beyond
// MAX_ELEMENTS are dropped and every result of that run carries rsp_tuser[0].
module insertion_sorter
   import isort_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,   // [31:0] value
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic                  rsp_tlast,
   output logic [0:0]            rsp_tuser    // [0] overflow
);

   cell_link_type cell_links [MAX_ELEMENTS];
   cell_ctrl_type ctrl;

   logic draining_ff;
   logic draining_in;
   logic dropped_ff;
   logic dropped_in;
   logic req_fire;
   logic rsp_fire;
   logic chain_full;

   assign chain_full = cell_links[MAX_ELEMENTS-1].valid;
   assign req_tready = !draining_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign ctrl.insert = req_fire && !chain_full;
   assign ctrl.shift  = rsp_fire;

   genvar i;
   generate
      for (i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
         cell_link_type prev_link;
         cell_link_type next_link;
         if (i == 0) begin : g_head
            assign prev_link = '{valid: 1'b1, gt: 1'b0, value: '0};
         end else begin : g_body
            assign prev_link = cell_links[i-1];
         end
         if (i == MAX_ELEMENTS - 1) begin : g_tail
            assign next_link = '{valid: 1'b0, gt: 1'b0, value: '0};
         end else begin : g_inner
            assign next_link = cell_links[i+1];
         end
         isort_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .new_value (req_tdata),
            .prev_link (prev_link),
            .next_link (next_link),
            .link      (cell_links[i])
         );
      end
   endgenerate

   always_comb begin
      draining_in = draining_ff;
      dropped_in  = dropped_ff;
      if (req_fire) begin
         if (chain_full) begin
            dropped_in = 1'b1;
         end
         if (req_tlast) begin
            draining_in = 1'b1;
         end
      end
      if (rsp_fire && rsp_tlast) begin
         draining_in = 1'b0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         dropped_ff  <= dropped_in;
      end
   end

   assign rsp_tvalid   = draining_ff && cell_links[0].valid;
   assign rsp_tdata    = cell_links[0].value;
   assign rsp_tlast    = !cell_links[1].valid;
   assign rsp_tuser[0] = dropped_ff;

endmodule

### design/isort_checker.sv
// ----------------------------------------------------------------------------
// isort_checker
// Port-level checks of the insertion sorter, bound to its top level.
// ----------------------------------------------------------------------------
module isort_checker
   import isort_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [DATA_WIDTH-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic [0:0]            rsp_tuser
);

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // a pending result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before transaction");

   // no input taken while a run drains
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during drain");

   // the final input of a run always yields a result
   a_last_yields: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> rsp_tvalid)
      else $error("no result after final input");

   // results leave in ascending order with a steady overflow flag
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_tlast |=> rsp_tvalid
         && ($signed(rsp_tdata) >= $signed($past(rsp_tdata)))
         && (rsp_tuser == $past(rsp_tuser)))
      else $error("result order or overflow flag broken");

   // drain ends with the marked result
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tlast |=> !rsp_tvalid)
      else $error("result after end of run");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
